>>> src/best_fit_bin_packing_defines.svh
`ifndef BEST_FIT_BIN_PACKING_DEFINES_SVH
`define BEST_FIT_BIN_PACKING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bfbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfbp_pkg;

    localparam int LEN_W     = 16;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STAT_W    = 2;

    localparam logic [LEN_W-1:0] CAP_RESET = 16'd1000;

    localparam logic [STAT_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_BIN   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

endpackage

`default_nettype wire

>>> src/bfbp_best.sv
`timescale 1ns / 1ps
`default_nettype none

module bfbp_best #(
    parameter int IDX_W = 6
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  bfbp_pkg::t_scan_ctl           i_ctl,
    input  wire [IDX_W-1:0]               i_idx,
    input  wire [bfbp_pkg::LEN_W-1:0]     i_rem,
    input  wire [bfbp_pkg::LEN_W-1:0]     i_len,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_best_idx,
    output logic [bfbp_pkg::LEN_W-1:0]    o_best_left
);

    logic                       r_found;
    logic [IDX_W-1:0]           r_best_idx;
    logic [bfbp_pkg::LEN_W-1:0] r_best_left;
    logic                       fit;
    logic [bfbp_pkg::LEN_W-1:0] left;
    logic                       take;

    assign fit  = (i_rem >= i_len);
    assign left = i_rem - i_len;
    // strict compare keeps the lowest index on ties
    assign take = i_ctl.vld && fit && (!r_found || (left < r_best_left));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clr) begin
            r_best_idx  <= i_idx;
            r_best_left <= left;
        end
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_best_left = r_best_left;

endmodule

`default_nettype wire

>>> src/best_fit_bin_packing.sv
// The single read port of the bin memory is walked one bin per cycle over the open bins,
// then come a drain step, the write-back and the result strobe; an item longer than the
// capacity skips the walk. Busy holds from the accepting edge through the write-back, so
// a new item is taken only once the previous one is through. The receiver cannot stall.
// Reset: synchronous, active low; clears the open bin count, capacity goes to 1000.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_bin_packing #(
    parameter int MAX_BINS = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [bfbp_pkg::LEN_W-1:0]        i_item_length,
    input  wire                               i_last_item,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bfbp_pkg::LEN_W-1:0]        i_cfg_data,
    output logic                              o_result_valid,
    output logic [bfbp_pkg::IDX_OUT_W-1:0]    o_bin_index,
    output logic                              o_opened_new,
    output logic [bfbp_pkg::LEN_W-1:0]        o_remaining_after,
    output logic [bfbp_pkg::CNT_OUT_W-1:0]    o_bins_used,
    output logic [bfbp_pkg::STAT_W-1:0]       o_status
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    bfbp_pkg::t_state r_state, n_state;

    logic [bfbp_pkg::LEN_W-1:0] r_cap;
    logic [bfbp_pkg::LEN_W-1:0] r_len;
    logic                       r_last;
    logic                       r_too_long;
    logic [CW-1:0]              r_addr;
    logic [CW-1:0]              r_count;
    logic                       r_cmp_vld;
    logic [IW-1:0]              r_cmp_idx;
    logic [bfbp_pkg::LEN_W-1:0] r_rdata;

    logic [bfbp_pkg::LEN_W-1:0] mem [MAX_BINS];

    logic                       accept;
    logic                       too_long_in;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [bfbp_pkg::LEN_W-1:0] wr_data;

    bfbp_pkg::t_scan_ctl        scan_ctl;
    logic                       found;
    logic [IW-1:0]              best_idx;
    logic [bfbp_pkg::LEN_W-1:0] best_left;

    logic                       r_res_vld;
    logic [bfbp_pkg::IDX_OUT_W-1:0] r_res_idx;
    logic                       r_res_new;
    logic [bfbp_pkg::LEN_W-1:0] r_res_left;
    logic [bfbp_pkg::CNT_OUT_W-1:0] r_res_used;
    logic [bfbp_pkg::STAT_W-1:0] r_res_stat;

    assign busy        = (r_state != bfbp_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign too_long_in = (i_item_length > r_cap);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bfbp_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // read address sequencing
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            bfbp_pkg::S_IDLE: begin
                rd_en = accept && !too_long_in && (r_count != '0);
            end
            bfbp_pkg::S_SCAN: begin
                rd_en   = (r_addr < r_count);
                rd_addr = r_addr[IW-1:0];
            end
            bfbp_pkg::S_WRITE: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // write-back decision
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = best_idx;
        wr_data = best_left;
        if ((r_state == bfbp_pkg::S_WRITE) && !r_too_long) begin
            if (found) begin
                wr_en = 1'b1;
            end else if (r_count != CW'(MAX_BINS)) begin
                wr_en   = 1'b1;
                wr_addr = r_count[IW-1:0];
                wr_data = r_cap - r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        r_cmp_idx <= rd_addr;
    end

    assign scan_ctl.clr = accept;
    assign scan_ctl.vld = r_cmp_vld;

    bfbp_best #(
        .IDX_W(IW)
    ) u_best (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_idx      (r_cmp_idx),
        .i_rem      (r_rdata),
        .i_len      (r_len),
        .o_found    (found),
        .o_best_idx (best_idx),
        .o_best_left(best_left)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfbp_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = bfbp_pkg::S_SCAN;
                end
            end
            bfbp_pkg::S_SCAN: begin
                // no compare pending: the last bin has been seen
                if (!r_cmp_vld) begin
                    n_state = bfbp_pkg::S_WRITE;
                end
            end
            bfbp_pkg::S_WRITE: begin
                n_state = bfbp_pkg::S_IDLE;
            end
            default: begin
                n_state = bfbp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfbp_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
            r_addr    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            r_res_vld <= (r_state == bfbp_pkg::S_WRITE);
            if (accept) begin
                r_addr <= CW'(1);
            end else if (rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
            if (r_state == bfbp_pkg::S_WRITE) begin
                if (r_last) begin
                    r_count <= '0;
                end else if (wr_en && !found) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len      <= i_item_length;
            r_last     <= i_last_item;
            r_too_long <= too_long_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bfbp_pkg::S_WRITE) begin
            r_res_idx  <= '0;
            r_res_new  <= 1'b0;
            r_res_left <= '0;
            r_res_used <= bfbp_pkg::CNT_OUT_W'(r_count);
            if (r_too_long) begin
                r_res_stat <= bfbp_pkg::ST_TOO_LONG;
            end else if (found) begin
                r_res_stat <= bfbp_pkg::ST_PLACED;
                r_res_idx  <= bfbp_pkg::IDX_OUT_W'(best_idx);
                r_res_left <= best_left;
            end else if (r_count == CW'(MAX_BINS)) begin
                r_res_stat <= bfbp_pkg::ST_NO_BIN;
            end else begin
                r_res_stat <= bfbp_pkg::ST_PLACED;
                r_res_idx  <= bfbp_pkg::IDX_OUT_W'(r_count);
                r_res_new  <= 1'b1;
                r_res_left <= r_cap - r_len;
                r_res_used <= bfbp_pkg::CNT_OUT_W'(r_count + CW'(1));
            end
        end
    end

    assign o_result_valid    = r_res_vld;
    assign o_bin_index       = r_res_idx;
    assign o_opened_new      = r_res_new;
    assign o_remaining_after = r_res_left;
    assign o_bins_used       = r_res_used;
    assign o_status          = r_res_stat;

endmodule

`default_nettype wire

>>> src/bfbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_bin_packing_defines.svh"

module bfbp_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               start,
    input wire                               busy,
    input wire                               o_result_valid,
    input wire [bfbp_pkg::IDX_OUT_W-1:0]     o_bin_index,
    input wire                               o_opened_new,
    input wire [bfbp_pkg::LEN_W-1:0]         o_remaining_after,
    input wire [bfbp_pkg::STAT_W-1:0]        o_status
);

    `BFBP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not raise busy")

    `BFBP_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy, "result strobe while busy")

    `BFBP_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_result_valid && (o_status != bfbp_pkg::ST_PLACED), (o_bin_index == '0) && !o_opened_new && (o_remaining_after == '0), "rejected transaction with nonzero fields")

    `BFBP_ASSERT_NOW(a_new_placed, i_clk, i_rst_n, o_result_valid && o_opened_new, o_status == bfbp_pkg::ST_PLACED, "new bin opened without placement")

endmodule

bind best_fit_bin_packing bfbp_checker u_bfbp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_bin_index      (o_bin_index),
    .o_opened_new     (o_opened_new),
    .o_remaining_after(o_remaining_after),
    .o_status         (o_status)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_BINS    = 64;
    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [bfbp_pkg::LEN_W-1:0] length;
        logic                       last;
    } t_item;

    typedef struct {
        logic [bfbp_pkg::IDX_OUT_W-1:0] bin_index;
        logic                           opened_new;
        logic [bfbp_pkg::LEN_W-1:0]     remaining_after;
        logic [bfbp_pkg::CNT_OUT_W-1:0] bins_used;
        logic [bfbp_pkg::STAT_W-1:0]    status;
    } t_placement;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [bfbp_pkg::LEN_W-1:0]     i_item_length;
    logic                           i_last_item;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bfbp_pkg::LEN_W-1:0]     i_cfg_data;
    logic                           o_result_valid;
    logic [bfbp_pkg::IDX_OUT_W-1:0] o_bin_index;
    logic                           o_opened_new;
    logic [bfbp_pkg::LEN_W-1:0]     o_remaining_after;
    logic [bfbp_pkg::CNT_OUT_W-1:0] o_bins_used;
    logic [bfbp_pkg::STAT_W-1:0]    o_status;

    // packing state mirrored from the block
    logic [bfbp_pkg::LEN_W-1:0] bin_space [MAX_BINS];
    int                         open_bins;
    logic [bfbp_pkg::LEN_W-1:0] capacity;

    t_item      pending_items[$];
    t_placement expected_placements[$];
    int         fail_count;
    int         cycle_count;
    int         burst_left;
    int         gap_left;

    best_fit_bin_packing #(
        .MAX_BINS(MAX_BINS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_item_length    (i_item_length),
        .i_last_item      (i_last_item),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_bin_index      (o_bin_index),
        .o_opened_new     (o_opened_new),
        .o_remaining_after(o_remaining_after),
        .o_bins_used      (o_bins_used),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_placement place_item(logic [bfbp_pkg::LEN_W-1:0] len, logic last);
        t_placement                 p;
        logic                       found;
        int                         best;
        logic [bfbp_pkg::LEN_W-1:0] best_left;
        p.bin_index       = '0;
        p.opened_new      = 1'b0;
        p.remaining_after = '0;
        p.status          = bfbp_pkg::ST_PLACED;
        found             = 1'b0;
        best              = 0;
        best_left         = '0;
        if (len > capacity) begin
            p.status = bfbp_pkg::ST_TOO_LONG;
        end else begin
            // tightest fit, lowest index on ties
            for (int j = 0; j < open_bins; j++) begin
                if (bin_space[j] >= len && (!found || bin_space[j] - len < best_left)) begin
                    found     = 1'b1;
                    best      = j;
                    best_left = bin_space[j] - len;
                end
            end
            if (found) begin
                bin_space[best]   = best_left;
                p.bin_index       = best[bfbp_pkg::IDX_OUT_W-1:0];
                p.remaining_after = best_left;
            end else if (open_bins >= MAX_BINS) begin
                p.status = bfbp_pkg::ST_NO_BIN;
            end else begin
                p.bin_index          = open_bins[bfbp_pkg::IDX_OUT_W-1:0];
                p.remaining_after    = capacity - len;
                bin_space[open_bins] = capacity - len;
                open_bins++;
                p.opened_new = 1'b1;
            end
        end
        p.bins_used = open_bins[bfbp_pkg::CNT_OUT_W-1:0];
        if (last)
            open_bins = 0;
        return p;
    endfunction

    // driver: bursts of items with random gaps, item held until accepted
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            start         <= 1'b0;
            i_item_length <= '0;
            i_last_item   <= 1'b0;
            burst_left    <= 1;
            gap_left      <= 0;
        end else begin
            if (start && !busy)
                expected_placements.push_back(place_item(i_item_length, i_last_item));
            if (start && busy) begin
                // hold the transaction
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                start         <= 1'b1;
                i_item_length <= it.length;
                i_last_item   <= it.last;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200)
                                                              : $urandom_range(1, 8);
                    gap_left   <= $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: one strobe per result, compared against the oldest prediction
    always @(posedge i_clk) begin
        t_placement e;
        if (i_rst_n && o_result_valid) begin
            if (expected_placements.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("unexpected result: bin %0d new %0b left %0d used %0d status %0d",
                             o_bin_index, o_opened_new, o_remaining_after, o_bins_used, o_status);
            end else begin
                e = expected_placements.pop_front();
                if (o_bin_index !== e.bin_index || o_opened_new !== e.opened_new ||
                    o_remaining_after !== e.remaining_after || o_bins_used !== e.bins_used ||
                    o_status !== e.status) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) begin
                        $display("mismatch: exp bin %0d new %0b left %0d used %0d status %0d",
                                 e.bin_index, e.opened_new, e.remaining_after, e.bins_used,
                                 e.status);
                        $display("          got bin %0d new %0b left %0d used %0d status %0d",
                                 o_bin_index, o_opened_new, o_remaining_after,
                                 o_bins_used, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_item(int len, logic last);
        t_item it;
        it.length = len[bfbp_pkg::LEN_W-1:0];
        it.last   = last;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || expected_placements.size() != 0 || start || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[bfbp_pkg::LEN_W-1:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        capacity = value[bfbp_pkg::LEN_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length(int cap);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return cap;
            2:       return $urandom_range(0, 65535);
            3:       return (cap < 65535) ? $urandom_range(cap + 1, 65535) : cap;
            4:       return $urandom_range(0, (cap > 8) ? cap / 8 : cap);
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    initial begin
        int queued;
        int cap;
        int jobs;
        int n;
        logic last;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item_length = '0;
        i_last_item   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        fail_count    = 0;
        cycle_count   = 0;
        open_bins     = 0;
        capacity      = bfbp_pkg::CAP_RESET;
        queued        = 0;
        burst_left    = 1;
        gap_left      = 0;
        for (int k = 0; k < MAX_BINS; k++)
            bin_space[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity: zero length, exact fill, too long, tightest fit, rejected last
        queue_item(0, 1'b0);
        queue_item(1000, 1'b0);
        queue_item(1001, 1'b0);
        queue_item(65535, 1'b0);
        queue_item(500, 1'b0);
        queue_item(0, 1'b0);
        queue_item(300, 1'b0);
        queue_item(2000, 1'b1);
        wait_idle();
        write_capacity(65535);
        queue_item(65535, 1'b0);
        queue_item(0, 1'b0);
        queue_item(32768, 1'b0);
        queue_item(1, 1'b1);
        wait_idle();
        write_capacity(0);
        queue_item(0, 1'b0);
        queue_item(1, 1'b0);
        queue_item(0, 1'b1);
        wait_idle();
        // capacity raised with a bin still open
        write_capacity(100);
        queue_item(50, 1'b0);
        wait_idle();
        write_capacity(1000);
        queue_item(60, 1'b0);
        queue_item(40, 1'b1);
        wait_idle();

        while (queued < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       cap = 1;
                1:       cap = 65535;
                2:       cap = $urandom_range(1, 65535);
                3:       cap = $urandom_range(1, 50);
                default: cap = $urandom_range(100, 5000);
            endcase
            write_capacity(cap);
            jobs = $urandom_range(1, 4);
            for (int jb = 0; jb < jobs; jb++) begin
                if ($urandom_range(0, 5) == 0) begin
                    // more than half a bin each: fills every bin, then can run out
                    n = $urandom_range(64, 72);
                    for (int i = 0; i < n; i++) begin
                        last = (i == n - 1) && !(jb == jobs - 1 && $urandom_range(0, 3) == 0);
                        queue_item($urandom_range(cap / 2 + 1, cap), last);
                    end
                end else begin
                    n = $urandom_range(1, 30);
                    for (int i = 0; i < n; i++) begin
                        last = (i == n - 1) ? !(jb == jobs - 1 && $urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 30) == 0);
                        queue_item(pick_length(cap), last);
                    end
                end
                queued += n;
            end
            wait_idle();
        end

        wait_idle();
        repeat (70) @(posedge i_clk);
        if (fail_count == 0 && expected_placements.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
